>>> src/mrsl_pkg.sv
// Shared types and constants for the multichannel sample ring log.
// Used by the controller, the datapath and the top level; no dependencies.
package mrsl_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int LOG_DEPTH    = 1024;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int ADDR_W = CH_W + PTR_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int ENTRY_W   = 64;

  // Field widths of a request and a result
  localparam int CMD_W   = 2;
  localparam int CHAN_W  = 8;
  localparam int TIME_W  = 64;
  localparam int VALUE_W = 32;
  localparam int IVL_W   = 32;
  localparam int RIDX_W  = 10;
  localparam int COUNT_W = 11;

  // Request tdata layout, lowest bit first
  localparam int IN_CHAN_LSB = 0;
  localparam int IN_TIME_LSB = IN_CHAN_LSB + CHAN_W;
  localparam int IN_VAL_LSB  = IN_TIME_LSB + TIME_W;
  localparam int IN_IVL_LSB  = IN_VAL_LSB + VALUE_W;
  localparam int IN_RIDX_LSB = IN_IVL_LSB + IVL_W;
  localparam int IN_USED_W   = IN_RIDX_LSB + RIDX_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Result tdata layout, lowest bit first
  localparam int OUT_TS_LSB  = 0;
  localparam int OUT_VAL_LSB = OUT_TS_LSB + VALUE_W;
  localparam int OUT_CNT_LSB = OUT_VAL_LSB + VALUE_W;
  localparam int OUT_USED_W  = OUT_CNT_LSB + COUNT_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Result tuser bits
  localparam int OUT_USER_W   = 3;
  localparam int USER_STATUS  = 0;
  localparam int USER_LOGGED  = 1;
  localparam int USER_RVALID  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_REGISTER = 2'd1,
    CMD_EMPTY    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // capture request, issue entry read
    logic commit;  // update tables, write entry, load result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_sts_t;

endpackage

>>> src/multichannel_rate_sampler_ring_log.sv
// Top level of the multichannel timestamped sample ring log.
// Depends on mrsl_pkg, mrsl_ctrl, mrsl_dp (and mrsl_ram below it).
//
//  Channel        Direction  Bits  Contents (lowest bit first)
//  s_axis (req)   in         152   tdata: channel, time_usec, sample_value,
//                                  interval_usec, read_index; tuser: cmd
//  m_axis (res)   out        80    tdata: read_timestamp, read_value,
//                                  sample_count; tuser: status, logged,
//                                  read_valid
//  cfg            in         1     run_enable, written when cfg_we_i is high
//
// Each request is handled in an accept step, which issues the entry store
// read, and an execute step, which does the read-modify-write of the
// channel's table row, any store write, and loads the result register.
// The execute step holds while a previous result is still unclaimed on
// m_axis; s_axis_tready stays low until the request commits.
// Reset clears the channel tables and run_enable at once; the entry store
// is never cleared, as a slot is only read back below the channel's count.
module multichannel_rate_sampler_ring_log
  import mrsl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration: run_enable
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] channel, [71:8] time_usec, [103:72] sample_value,
  // [135:104] interval_usec, [145:136] read_index, [151:146] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] read_timestamp, [63:32] read_value, [74:64] sample_count,
  // [79:75] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] status, [1] logged, [2] read_valid
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // Sequence each request: accept, then commit when the result slot frees
  mrsl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (dp_sts),
    .cmd_o     (ctrl_cmd)
  );

  // Tables, entry store and result register
  mrsl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

  // One request at a time: an accepted request is never followed by
  // another accept in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous one still executing");

  // A logging sample always succeeds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[USER_LOGGED] && m_axis_tuser[USER_STATUS]))
    else $error("logged sample reported failure");

  // A valid read or a logged sample implies a nonzero stored count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[USER_RVALID] || m_axis_tuser[USER_LOGGED]))
      |-> (m_axis_tdata[OUT_CNT_LSB +: COUNT_W] != '0))
    else $error("entry reported with zero sample count");

  // A commit loads the result register: valid must be up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.commit |=> m_axis_tvalid)
    else $error("committed request produced no result");

endmodule

>>> src/mrsl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mrsl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mrsl_ctrl.sv
// Sequencing controller: accept a request, then commit it once the result
// register is free. Depends on mrsl_pkg.
module mrsl_ctrl
  import mrsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o    = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
      end
      ST_EXEC: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/mrsl_dp.sv
// Datapath: request capture, per-channel tables, entry store and result
// register. Depends on mrsl_pkg and mrsl_ram.
module mrsl_dp
  import mrsl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_sts_t               sts_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [CMD_W-1:0]      s_tuser_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic [OUT_USER_W-1:0] m_tuser_o
);

  // Captured request
  cmd_e               cmd_q;
  logic [CHAN_W-1:0]  chan_q;
  logic [TIME_W-1:0]  time_q;
  logic [VALUE_W-1:0] val_q;
  logic [IVL_W-1:0]   ivl_q;
  logic [RIDX_W-1:0]  ridx_q;

  logic run_q;

  // Channel tables
  logic               en_q   [NUM_CHANNELS];
  logic [IVL_W-1:0]   ivl_tab_q  [NUM_CHANNELS];
  logic [TIME_W-1:0]  last_q [NUM_CHANNELS];
  logic [PTR_W-1:0]   ptr_q  [NUM_CHANNELS];
  logic [CNT_W-1:0]   cnt_q  [NUM_CHANNELS];

  // Result register
  logic               m_valid_q;
  logic               st_q, lg_q, rv_q;
  logic [VALUE_W-1:0] rts_q, rval_q;
  logic [CNT_W-1:0]   rcnt_q;

  logic [CHAN_W-1:0]  s_chan;
  logic [RIDX_W-1:0]  s_ridx;
  logic [ADDR_W-1:0]  raddr, waddr;
  logic [ENTRY_W-1:0] rdata, wdata;
  logic               we;

  logic [CH_W-1:0]    ci;
  logic               ch_ok;
  logic               cur_en;
  logic [TIME_W-1:0]  elapsed;
  logic               due;
  logic [PTR_W-1:0]   cur_ptr, ptr_next;
  logic [CNT_W-1:0]   cur_cnt, cnt_next;
  logic               do_log;
  logic               rd_hit;
  logic               st_d, lg_d, rv_d;
  logic [CNT_W-1:0]   rcnt_d;

  assign s_chan = s_tdata_i[IN_CHAN_LSB +: CHAN_W];
  assign s_ridx = s_tdata_i[IN_RIDX_LSB +: RIDX_W];
  assign raddr  = {s_chan[CH_W-1:0], s_ridx[PTR_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= cmd_e'(s_tuser_i);
      chan_q <= s_chan;
      time_q <= s_tdata_i[IN_TIME_LSB +: TIME_W];
      val_q  <= s_tdata_i[IN_VAL_LSB +: VALUE_W];
      ivl_q  <= s_tdata_i[IN_IVL_LSB +: IVL_W];
      ridx_q <= s_ridx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (cfg_we_i) begin
      run_q <= cfg_wdata_i;
    end
  end

  // Decode the held request against its channel's table row
  assign ci       = chan_q[CH_W-1:0];
  assign ch_ok    = {1'b0, chan_q} < (CHAN_W + 1)'(NUM_CHANNELS);
  assign cur_en   = en_q[ci];
  assign cur_ptr  = ptr_q[ci];
  assign cur_cnt  = cnt_q[ci];
  assign elapsed  = time_q - last_q[ci];
  assign due      = elapsed >= {{(TIME_W - IVL_W){1'b0}}, ivl_tab_q[ci]};
  assign ptr_next = (cur_ptr == PTR_W'(LOG_DEPTH - 1)) ? '0 : cur_ptr + 1'b1;
  assign cnt_next = (cur_cnt == CNT_W'(LOG_DEPTH)) ? cur_cnt : cur_cnt + 1'b1;
  assign do_log   = ch_ok && (cmd_q == CMD_SAMPLE) && run_q && cur_en && due;
  assign rd_hit   = ch_ok && (cmd_q == CMD_READ) && cur_en &&
                    (CNT_W'(ridx_q) < cur_cnt);

  always_comb begin
    st_d   = 1'b0;
    lg_d   = 1'b0;
    rv_d   = 1'b0;
    rcnt_d = '0;
    if (!ch_ok) begin
      st_d = 1'b1;
    end else begin
      unique case (cmd_q)
        CMD_SAMPLE: begin
          lg_d   = do_log;
          rcnt_d = do_log ? cnt_next : cur_cnt;
        end
        CMD_REGISTER: rcnt_d = cur_cnt;
        CMD_EMPTY:    rcnt_d = '0;
        CMD_READ: begin
          st_d   = !cur_en;
          rv_d   = rd_hit;
          rcnt_d = cur_cnt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        en_q[i]      <= 1'b0;
        ivl_tab_q[i] <= '0;
        last_q[i]    <= '0;
        ptr_q[i]     <= '0;
        cnt_q[i]     <= '0;
      end
    end else if (cmd_i.commit && ch_ok) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (ci == CH_W'(i)) begin
          unique case (cmd_q)
            CMD_SAMPLE: begin
              if (do_log) begin
                last_q[i] <= time_q;
                ptr_q[i]  <= ptr_next;
                cnt_q[i]  <= cnt_next;
              end
            end
            CMD_REGISTER: begin
              ivl_tab_q[i] <= ivl_q;
              last_q[i]    <= '0;
              en_q[i]      <= 1'b1;
            end
            CMD_EMPTY: begin
              ptr_q[i]  <= '0;
              cnt_q[i]  <= '0;
              last_q[i] <= '0;
            end
            CMD_READ: ;
            default: ;
          endcase
        end
      end
    end
  end

  assign we    = cmd_i.commit && do_log;
  assign waddr = {ci, cur_ptr};
  assign wdata = {val_q, time_q[VALUE_W-1:0]};

  mrsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.out_free = !m_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      st_q   <= st_d;
      lg_q   <= lg_d;
      rv_q   <= rv_d;
      rts_q  <= rd_hit ? rdata[VALUE_W-1:0] : '0;
      rval_q <= rd_hit ? rdata[ENTRY_W-1:VALUE_W] : '0;
      rcnt_q <= rcnt_d;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                       COUNT_W'(rcnt_q), rval_q, rts_q};
  assign m_tuser_o  = {rv_q, lg_q, st_q};

endmodule
